// ----- hdl/swlm_pkg.sv -----
// Shared widths, types and register codes for the smoothed wet lowpass mixer.
`default_nettype none
package swlm_pkg;

    // Field and coefficient formats
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int COEF_FRAC   = COEF_BITS - 3;
    localparam int STATE_FRAC  = 12;
    localparam int FB_FRAC     = 7;
    localparam int FB_BITS     = SAMPLE_BITS + FB_FRAC + 1;
    localparam int DIFF_BITS   = FB_BITS + 1;
    localparam int DELAY_BITS  = 48;
    localparam int Q16_BITS    = 17;
    localparam int INT_BITS    = 33;
    localparam int K_BITS      = 20;

    localparam logic [Q16_BITS-1:0] ONE_Q16  = Q16_BITS'(65536);
    localparam logic [K_BITS-1:0]   SMOOTH_K = K_BITS'(429497);

    // Rounding shift amounts
    localparam int SHIFT_BX     = COEF_FRAC - STATE_FRAC;
    localparam int SHIFT_FB     = COEF_FRAC + FB_FRAC - STATE_FRAC;
    localparam int SHIFT_Y      = STATE_FRAC - FB_FRAC;
    localparam int SHIFT_Q32    = 32;
    localparam int SHIFT_MIX    = 16 + FB_FRAC;

    // Shared multiplier operand width covers coefficients, mix difference
    // and the unsigned intensity terms
    localparam int MUL_BITS_0 = (COEF_BITS > DIFF_BITS) ? COEF_BITS : DIFF_BITS;
    localparam int MUL_BITS   = (MUL_BITS_0 > INT_BITS + 1) ? MUL_BITS_0 : INT_BITS + 1;
    localparam int PROD_BITS  = 2 * MUL_BITS;

    // Internal accumulator widths
    localparam int BX_BITS    = COEF_BITS + SAMPLE_BITS - SHIFT_BX + 2;
    localparam int T_BITS     = COEF_BITS + FB_BITS - SHIFT_FB + 1;
    localparam int ACC_BITS_0 = (BX_BITS > T_BITS) ? BX_BITS : T_BITS;
    localparam int ACC_BITS   = ((ACC_BITS_0 > DELAY_BITS) ? ACC_BITS_0 : DELAY_BITS) + 2;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COEF_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HUMIDITY = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WET_MIX  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B0  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A1  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A2  = 3'd5;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic        [Q16_BITS-1:0]    q16_t;
    typedef logic signed [MUL_BITS-1:0]    mul_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;

    // Register file contents as seen by the datapath
    typedef struct packed {
        logic  enable;
        q16_t  humidity;
        q16_t  wet_mix;
        coef_t coef_b0;
        coef_t coef_a1;
        coef_t coef_a2;
    } cfg_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic en;
        mul_t a;
        mul_t b;
    } mul_req_t;

endpackage
`default_nettype wire

// ----- hdl/swlm_ifs.sv -----
// Stream and configuration channel interfaces of the mixer.
`default_nettype none

// Input sample channel
interface swlm_in_if;
    logic                 valid;
    logic                 ready;
    swlm_pkg::sample_t    sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// Output sample channel
interface swlm_out_if;
    logic                 valid;
    logic                 ready;
    swlm_pkg::sample_t    sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// Register write channel
interface swlm_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [swlm_pkg::CFG_IDX_BITS-1:0]      index;
    logic [swlm_pkg::CFG_DATA_BITS-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/swlm_regs.sv -----
// Configuration register file of the mixer.
`default_nettype none
module swlm_regs
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    swlm_cfg_if.sink       cfg_ch,
    output swlm_pkg::cfg_t cfg
);

    swlm_pkg::cfg_t cfg_reg;

    // Writes are always taken
    assign cfg_ch.ready = 1'b1;
    assign cfg          = cfg_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                swlm_pkg::REG_ENABLE:   cfg_reg.enable   <= cfg_ch.data[0];
                swlm_pkg::REG_HUMIDITY: cfg_reg.humidity <= cfg_ch.data[swlm_pkg::Q16_BITS-1:0];
                swlm_pkg::REG_WET_MIX:  cfg_reg.wet_mix  <= cfg_ch.data[swlm_pkg::Q16_BITS-1:0];
                swlm_pkg::REG_COEF_B0:  cfg_reg.coef_b0  <= cfg_ch.data[swlm_pkg::COEF_BITS-1:0];
                swlm_pkg::REG_COEF_A1:  cfg_reg.coef_a1  <= cfg_ch.data[swlm_pkg::COEF_BITS-1:0];
                swlm_pkg::REG_COEF_A2:  cfg_reg.coef_a2  <= cfg_ch.data[swlm_pkg::COEF_BITS-1:0];
                default:                cfg_reg          <= cfg_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hdl/swlm_mul.sv -----
// Shared signed multiplier with a registered product.
`default_nettype none
module swlm_mul
(
    input  wire logic               clk,
    input  wire swlm_pkg::mul_req_t req,
    output swlm_pkg::prod_t         prod
);

    swlm_pkg::prod_t prod_reg;

    assign prod = prod_reg;

    // Product holds until the next request
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= req.a * req.b;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/swlm_core.sv -----
// Sequencer and datapath: lowpass, intensity smoothing and dry/wet mix.
`default_nettype none
module swlm_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    swlm_in_if.sink                 in_ch,
    swlm_out_if.source              out_ch,
    input  wire swlm_pkg::cfg_t     cfg,
    output swlm_pkg::mul_req_t      mul_req,
    input  wire swlm_pkg::prod_t    prod
);

    typedef logic signed [swlm_pkg::ACC_BITS-1:0]   acc_t;
    typedef logic signed [swlm_pkg::BX_BITS-1:0]    bx_t;
    typedef logic signed [swlm_pkg::FB_BITS-1:0]    fb_t;
    typedef logic signed [swlm_pkg::DIFF_BITS-1:0]  diff_t;
    typedef logic signed [swlm_pkg::DELAY_BITS-1:0] delay_t;
    typedef logic        [swlm_pkg::INT_BITS-1:0]   int_t;

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SMK  = 4'd1;
    localparam logic [3:0] ST_BX   = 4'd2;
    localparam logic [3:0] ST_BXD  = 4'd3;
    localparam logic [3:0] ST_YF   = 4'd4;
    localparam logic [3:0] ST_A1   = 4'd5;
    localparam logic [3:0] ST_A2   = 4'd6;
    localparam logic [3:0] ST_DLY  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    // Round half up, then shift right
    function automatic swlm_pkg::prod_t rnd_prod(input swlm_pkg::prod_t v, input int unsigned n);
        return (v + (swlm_pkg::prod_t'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic acc_t rnd_acc(input acc_t v, input int unsigned n);
        return (v + (acc_t'(1) <<< (n - 1))) >>> n;
    endfunction

    // Clamp to a signed range of the given width
    function automatic acc_t sat_acc(input acc_t v, input int unsigned bits);
        acc_t hi;
        acc_t lo;
        hi = (acc_t'(1) <<< (bits - 1)) - acc_t'(1);
        lo = ~hi;
        if (v > hi)
            return hi;
        else if (v < lo)
            return lo;
        return v;
    endfunction

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic                out_valid_reg;
    swlm_pkg::sample_t   out_data_reg;

    // Filter and smoothing state
    delay_t              d1_reg;
    delay_t              d2_reg;
    int_t                s_reg;

    // Per-word working registers
    swlm_pkg::sample_t   x_reg;
    int_t                sdiff_reg;
    logic                sge_reg;
    bx_t                 bx_reg;
    bx_t                 b2x_reg;
    swlm_pkg::q16_t      w_reg;
    fb_t                 yf_reg;
    diff_t               diff_reg;
    acc_t                t_reg;

    logic                bypass;
    logic                in_take;
    logic                out_free;
    swlm_pkg::q16_t      hum_cl;
    swlm_pkg::q16_t      wm_cl;
    int_t                target;
    logic                tgt_ge;
    swlm_pkg::prod_t     rs_bx;
    swlm_pkg::prod_t     rs_b2x;
    swlm_pkg::prod_t     rs_q32;
    swlm_pkg::prod_t     rs_fb;
    swlm_pkg::prod_t     rs_mix;
    int_t                step;
    int_t                s_new;
    acc_t                y_sum;
    acc_t                y_rnd;
    acc_t                yf_sat;
    acc_t                fb_term;
    acc_t                d1_sat;
    acc_t                d2_sat;
    acc_t                mix_term;
    acc_t                mix_sat;

    // Handshake
    assign out_free         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready      = (state_reg == ST_IDLE) && out_free;
    assign in_take          = in_ch.valid && in_ch.ready;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.sample_out = out_data_reg;

    // Settings above one saturate
    assign bypass = !cfg.enable || (cfg.humidity == '0);
    assign hum_cl = (cfg.humidity > swlm_pkg::ONE_Q16) ? swlm_pkg::ONE_Q16 : cfg.humidity;
    assign wm_cl  = (cfg.wet_mix > swlm_pkg::ONE_Q16) ? swlm_pkg::ONE_Q16 : cfg.wet_mix;
    assign target = {hum_cl, 16'b0};
    assign tgt_ge = target >= s_reg;

    // Rounded views of the product
    assign rs_bx  = rnd_prod(prod, swlm_pkg::SHIFT_BX);
    assign rs_b2x = rnd_prod(prod, swlm_pkg::SHIFT_BX - 1);
    assign rs_q32 = rnd_prod(prod, swlm_pkg::SHIFT_Q32);
    assign rs_fb  = rnd_prod(prod, swlm_pkg::SHIFT_FB);
    assign rs_mix = rnd_prod(prod, swlm_pkg::SHIFT_MIX);

    // Intensity step toward the target
    assign step  = rs_q32[swlm_pkg::INT_BITS-1:0];
    assign s_new = sge_reg ? (s_reg + step) : (s_reg - step);

    // Feedback value
    assign y_sum  = acc_t'(bx_reg) + acc_t'(d1_reg);
    assign y_rnd  = rnd_acc(y_sum, swlm_pkg::SHIFT_Y);
    assign yf_sat = sat_acc(y_rnd, swlm_pkg::FB_BITS);

    // Delay updates
    assign fb_term = rs_fb[swlm_pkg::ACC_BITS-1:0];
    assign d2_sat  = sat_acc(acc_t'(bx_reg) - fb_term, swlm_pkg::DELAY_BITS);
    assign d1_sat  = sat_acc(t_reg + acc_t'(d2_reg), swlm_pkg::DELAY_BITS);

    // Final mix
    assign mix_term = rs_mix[swlm_pkg::ACC_BITS-1:0];
    assign mix_sat  = sat_acc(acc_t'(x_reg) + mix_term, swlm_pkg::SAMPLE_BITS);

    // Next state and multiplier operand select
    always_comb
    begin
        state_next = state_reg;
        mul_req.en = 1'b0;
        mul_req.a  = '0;
        mul_req.b  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && !bypass)
                    state_next = ST_SMK;
            end
            ST_SMK:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = swlm_pkg::mul_t'(sdiff_reg);
                mul_req.b  = swlm_pkg::mul_t'(swlm_pkg::SMOOTH_K);
                state_next = ST_BX;
            end
            ST_BX:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = swlm_pkg::mul_t'(cfg.coef_b0);
                mul_req.b  = swlm_pkg::mul_t'(x_reg);
                state_next = ST_BXD;
            end
            ST_BXD:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = swlm_pkg::mul_t'(s_reg);
                mul_req.b  = swlm_pkg::mul_t'(wm_cl);
                state_next = ST_YF;
            end
            ST_YF:
            begin
                state_next = ST_A1;
            end
            ST_A1:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = swlm_pkg::mul_t'(cfg.coef_a1);
                mul_req.b  = swlm_pkg::mul_t'(yf_reg);
                state_next = ST_A2;
            end
            ST_A2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = swlm_pkg::mul_t'(cfg.coef_a2);
                mul_req.b  = swlm_pkg::mul_t'(yf_reg);
                state_next = ST_DLY;
            end
            ST_DLY:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = swlm_pkg::mul_t'(w_reg);
                mul_req.b  = swlm_pkg::mul_t'(diff_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            d1_reg        <= '0;
            d2_reg        <= '0;
            s_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // a new word wins over the one leaving in the same cycle
            if ((in_take && bypass) || (state_reg == ST_OUT && out_free))
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_BX)
                s_reg <= s_new;
            if (state_reg == ST_DLY)
            begin
                d1_reg <= d1_sat[swlm_pkg::DELAY_BITS-1:0];
                d2_reg <= d2_sat[swlm_pkg::DELAY_BITS-1:0];
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    x_reg     <= in_ch.sample_in;
                    sge_reg   <= tgt_ge;
                    sdiff_reg <= tgt_ge ? (target - s_reg) : (s_reg - target);
                    if (bypass)
                        out_data_reg <= in_ch.sample_in;
                end
            end
            ST_BXD:
            begin
                bx_reg  <= rs_bx[swlm_pkg::BX_BITS-1:0];
                b2x_reg <= rs_b2x[swlm_pkg::BX_BITS-1:0];
            end
            ST_YF:
            begin
                w_reg  <= rs_q32[swlm_pkg::Q16_BITS-1:0];
                yf_reg <= yf_sat[swlm_pkg::FB_BITS-1:0];
            end
            ST_A1:
            begin
                diff_reg <= diff_t'(yf_reg) - (diff_t'(x_reg) <<< swlm_pkg::FB_FRAC);
            end
            ST_A2:
            begin
                t_reg <= acc_t'(b2x_reg) - fb_term;
            end
            ST_OUT:
            begin
                if (out_free)
                    out_data_reg <= mix_sat[swlm_pkg::SAMPLE_BITS-1:0];
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/smoothed_wet_lowpass_mixer.sv -----
// Top level of the smoothed wet lowpass mixer, one audio channel.
//
// Channels: in_ch takes one signed sample word, out_ch returns one mixed
// sample word for each, in order; cfg_ch writes the six settings by index
// (enable, humidity, wet_mix, coef_b0, coef_a1, coef_a2) and is always
// ready. Write settings only while no word is in flight.
// A processed word runs through the sequencer states SMK to OUT, and
// the next word enters only when it is done; this is set by the single
// shared multiplier, which serves all six products in turn.
// In bypass (disabled or humidity zero) the word is copied to the output
// register on the input handshake, one word per cycle if out_ch keeps up.
// Reset clears the settings, both filter delays and the smoothed intensity.
// When the receiver stalls, the finished word holds in the output
// register; a new input word is taken in the same cycle the held word
// leaves, and a finished result waits in its last step until the output
// register frees.
`default_nettype none
module smoothed_wet_lowpass_mixer
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    swlm_in_if.sink        in_ch,
    swlm_out_if.source     out_ch,
    swlm_cfg_if.sink       cfg_ch
);

    swlm_pkg::cfg_t     cfg;
    swlm_pkg::mul_req_t mul_req;
    swlm_pkg::prod_t    prod;

    // Settings
    swlm_regs u_regs
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    // Shared multiplier
    swlm_mul u_mul
    (
        .clk    (clk),
        .req    (mul_req),
        .prod   (prod)
    );

    // Sequencer and datapath
    swlm_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg     (cfg),
        .mul_req (mul_req),
        .prod    (prod)
    );

endmodule
`default_nettype wire
